[rtl/slip_traction_pi_limiter_top_macros.svh]
`ifndef SLIP_TRACTION_PI_LIMITER_TOP_MACROS_SVH
`define SLIP_TRACTION_PI_LIMITER_TOP_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define STPL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stpl: same-cycle check failed");

// Next-cycle implication, checked only out of reset.
`define STPL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stpl: next-cycle check failed");

`endif

[rtl/stpl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package stpl_pkg;

    localparam int SLIP_FRAC_BITS_DEF = 16;
    localparam int RPM_BITS_DEF       = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int INTEG_W = 40;
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 20;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 38;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_GAIN       = 3'd0,
        CFG_KI_GAIN       = 3'd1,
        CFG_TARGET_SLIP   = 3'd2,
        CFG_MIN_FRONT_RPM = 3'd3,
        CFG_THROTTLE_GATE = 3'd4,
        CFG_EMA_ALPHA     = 3'd5
    } t_cfg_reg;

    localparam logic [15:0] KP_RST        = 16'd5000;
    localparam logic [15:0] KI_RST        = 16'd500;
    localparam logic [14:0] TARGET_RST    = 15'd6554;
    localparam logic [15:0] MIN_FRONT_RST = 16'd30;
    localparam logic [11:0] THR_GATE_RST  = 12'd1550;
    localparam logic [15:0] ALPHA_RST     = 16'd52429;

    localparam logic [13:0]        INTEG_SCALE = 14'd10000;
    localparam logic [8:0]         CORR_MAX    = 9'd500;
    localparam logic [11:0]        THR_LOW     = 12'd1500;
    localparam logic [11:0]        THR_HIGH    = 12'd2000;
    localparam logic [MUL_A_W-1:0] EMA_ONE     = 17'd65536;

    typedef struct packed {
        logic [15:0] front_rpm;
        logic [15:0] rear_rpm;
        logic [11:0] throttle_in;
    } t_in_word;

    typedef struct packed {
        logic [11:0] throttle_out;
        logic [15:0] slip_now;
        logic        limiting;
    } t_out_word;

    // One strobe per datapath step, issued by the sequencer.
    typedef struct packed {
        logic load;
        logic div_step;
        logic sat;
        logic mul_a;
        logic mul_b;
        logic filt;
        logic err;
        logic mul_i;
        logic integ;
        logic mul_lo;
        logic mul_hi;
        logic corr;
        logic out_load;
    } t_dp_cmd;

endpackage

`default_nettype wire

[rtl/slip_traction_pi_limiter_top.sv]
// Traction-control throttle limiter. One input word is one control tick:
// front and rear wheel RPM plus the commanded throttle pulse width. One
// output word per tick: limited throttle, filtered slip and a limiting flag.
// Input and output use valid/ready; configuration registers are written
// through a separate valid/ready port (index, data) that is always ready,
// and should only be written while no tick is in flight.
// The slip divider is a restoring divider producing one quotient bit per
// cycle, followed by ten steps from saturation to correction; their
// multiplies share one 17x20 multiplier. A new word is accepted only
// once the sequencer has finished the previous one and returned to idle.
// The next word may be accepted while the previous result still sits in
// the output register; if the receiver stalls, the sequencer holds at its
// last step until the output register frees up.
// Reset restores register defaults, clears the integral and the filter
// state and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

`include "slip_traction_pi_limiter_top_macros.svh"

module slip_traction_pi_limiter_top #(
    parameter int SLIP_FRAC_BITS = stpl_pkg::SLIP_FRAC_BITS_DEF,
    parameter int RPM_BITS       = stpl_pkg::RPM_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  stpl_pkg::t_in_word               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output stpl_pkg::t_out_word              o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [stpl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [stpl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import stpl_pkg::*;

    t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    stpl_ctrl #(
        .SLIP_FRAC_BITS (SLIP_FRAC_BITS),
        .RPM_BITS       (RPM_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    stpl_dp #(
        .SLIP_FRAC_BITS (SLIP_FRAC_BITS),
        .RPM_BITS       (RPM_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

    `STPL_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `STPL_ASSERT_NOW(a_limit_range, i_clk, i_rst_n, o_out_valid && o_out_data.limiting, (o_out_data.throttle_out >= THR_LOW) && (o_out_data.throttle_out <= THR_HIGH))
    `STPL_ASSERT_NOW(a_limit_has_slip, i_clk, i_rst_n, o_out_valid && o_out_data.limiting, o_out_data.slip_now != 16'd0)

endmodule

`default_nettype wire

[rtl/stpl_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module stpl_dp #(
    parameter int SLIP_FRAC_BITS = stpl_pkg::SLIP_FRAC_BITS_DEF,
    parameter int RPM_BITS       = stpl_pkg::RPM_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  stpl_pkg::t_dp_cmd                i_cmd,
    input  stpl_pkg::t_in_word               i_in_data,
    input  logic                             i_cfg_we,
    input  logic [stpl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [stpl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output stpl_pkg::t_out_word              o_out_data
);
    import stpl_pkg::*;

    localparam int DivW      = RPM_BITS + SLIP_FRAC_BITS;
    localparam int CmpW      = (RPM_BITS > 16) ? RPM_BITS : 16;
    localparam int SlipOneM1 = (1 << SLIP_FRAC_BITS) - 1;
    localparam int SlipMaxI  = (SlipOneM1 > 65535) ? 65535 : SlipOneM1;
    localparam logic [15:0] SlipMax = 16'(SlipMaxI);
    localparam int CorrW     = PROD_W + MUL_B_W + 1;

    // configuration and carried state
    logic [15:0]        r_kp;
    logic [15:0]        r_ki;
    logic [14:0]        r_target;
    logic [15:0]        r_min_front;
    logic [11:0]        r_thr_gate;
    logic [15:0]        r_alpha;
    logic [INTEG_W-1:0] r_integ;
    logic [15:0]        r_filt;

    // per-word working registers
    logic [RPM_BITS-1:0] r_front;
    logic [RPM_BITS-1:0] r_rem;
    logic [DivW-1:0]     r_num;
    logic [11:0]         r_thr;
    logic                r_gate;
    logic [15:0]         r_raw;
    logic [PROD_W-1:0]   r_prod;
    logic [ACC_W-1:0]    r_acc;
    logic [15:0]         r_slip;
    logic                r_limit;
    logic [15:0]         r_err;
    logic [8:0]          r_corr;
    t_out_word           r_out;

    logic [RPM_BITS-1:0] front_m;
    logic [RPM_BITS-1:0] rear_m;
    logic [RPM_BITS-1:0] diff;
    logic                gate;
    logic [RPM_BITS:0]   rem_sh;
    logic                q_bit;
    logic [RPM_BITS:0]   rem_nx;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   prod;
    logic                prod_en;
    logic [33:0]         filt_sum;
    logic [17:0]         filt_q;
    logic [15:0]         filt_c;
    logic [INTEG_W:0]    integ_sum;
    logic [CorrW-1:0]    corr_total;
    logic [CorrW-1:0]    corr_shr;
    logic signed [13:0]  thr_diff;
    logic [11:0]         thr_lim;

    // input capture and gate
    assign front_m = RPM_BITS'(i_in_data.front_rpm);
    assign rear_m  = RPM_BITS'(i_in_data.rear_rpm);
    assign diff    = (rear_m > front_m) ? (rear_m - front_m) : '0;
    assign gate    = (CmpW'(front_m) > CmpW'(r_min_front))
                  && (i_in_data.throttle_in > r_thr_gate);

    // restoring divider: one quotient bit per step, quotient shifts into r_num
    assign rem_sh = {r_rem, r_num[DivW-1]};
    assign q_bit  = rem_sh >= {1'b0, r_front};
    assign rem_nx = q_bit ? (rem_sh - {1'b0, r_front}) : rem_sh;

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.mul_a) begin
            mul_a = MUL_A_W'(r_alpha);
            mul_b = MUL_B_W'(r_raw);
        end else if (i_cmd.mul_b) begin
            mul_a = EMA_ONE - MUL_A_W'(r_alpha);
            mul_b = MUL_B_W'(r_filt);
        end else if (i_cmd.mul_i) begin
            mul_a = MUL_A_W'(INTEG_SCALE);
            mul_b = MUL_B_W'(r_err);
        end else if (i_cmd.integ) begin
            mul_a = MUL_A_W'(r_kp);
            mul_b = MUL_B_W'(r_err);
        end else if (i_cmd.mul_lo) begin
            mul_a = MUL_A_W'(r_ki);
            mul_b = r_integ[MUL_B_W-1:0];
        end else if (i_cmd.mul_hi) begin
            mul_a = MUL_A_W'(r_ki);
            mul_b = r_integ[INTEG_W-1:MUL_B_W];
        end
    end

    assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign prod_en = i_cmd.mul_a | i_cmd.mul_b | i_cmd.mul_i
                   | i_cmd.integ | i_cmd.mul_lo | i_cmd.mul_hi;

    // EMA: weighted sum, round half up, clamp
    assign filt_sum = 34'(r_acc[32:0]) + 34'(r_prod[32:0]) + 34'd32768;
    assign filt_q   = filt_sum[33:16];
    assign filt_c   = (filt_q > 18'(SlipMax)) ? SlipMax : filt_q[15:0];

    // integral with saturation at all ones
    assign integ_sum = {1'b0, r_integ} + (INTEG_W + 1)'(r_prod);

    // kp*err + ki*integral, high partial product weighted by 2^20
    assign corr_total = CorrW'(r_acc) + (CorrW'(r_prod) << MUL_B_W);
    assign corr_shr   = corr_total >> SLIP_FRAC_BITS;

    assign thr_diff = $signed({2'b00, r_thr}) - $signed({5'b00000, r_corr});
    always_comb begin
        if (thr_diff < $signed({2'b00, THR_LOW})) begin
            thr_lim = THR_LOW;
        end else if (thr_diff > $signed({2'b00, THR_HIGH})) begin
            thr_lim = THR_HIGH;
        end else begin
            thr_lim = thr_diff[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp        <= KP_RST;
            r_ki        <= KI_RST;
            r_target    <= TARGET_RST;
            r_min_front <= MIN_FRONT_RST;
            r_thr_gate  <= THR_GATE_RST;
            r_alpha     <= ALPHA_RST;
            r_integ     <= '0;
            r_filt      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_KP_GAIN:       r_kp        <= i_cfg_data;
                    CFG_KI_GAIN:       r_ki        <= i_cfg_data;
                    CFG_TARGET_SLIP:   r_target    <= i_cfg_data[14:0];
                    CFG_MIN_FRONT_RPM: r_min_front <= i_cfg_data;
                    CFG_THROTTLE_GATE: r_thr_gate  <= i_cfg_data[11:0];
                    CFG_EMA_ALPHA:     r_alpha     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.filt && r_gate) begin
                r_filt <= filt_c;
            end
            if (i_cmd.integ) begin
                if (!r_limit) begin
                    r_integ <= '0;
                end else if (integ_sum[INTEG_W]) begin
                    r_integ <= '1;
                end else begin
                    r_integ <= integ_sum[INTEG_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_front <= front_m;
            r_rem   <= '0;
            r_num   <= DivW'(diff) << SLIP_FRAC_BITS;
            r_thr   <= i_in_data.throttle_in;
            r_gate  <= gate;
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_nx[RPM_BITS-1:0];
            r_num <= {r_num[DivW-2:0], q_bit};
        end
        if (i_cmd.sat) begin
            r_raw <= (r_num > DivW'(SlipMax)) ? SlipMax : r_num[15:0];
        end
        if (prod_en) begin
            r_prod <= prod;
        end
        if (i_cmd.mul_b || i_cmd.mul_lo) begin
            r_acc <= ACC_W'(r_prod);
        end else if (i_cmd.mul_hi) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.filt) begin
            r_slip <= r_gate ? filt_c : '0;
        end
        if (i_cmd.err) begin
            r_limit <= r_slip > 16'(r_target);
            r_err   <= r_slip - 16'(r_target);
        end
        if (i_cmd.corr) begin
            r_corr <= (corr_shr > CorrW'(CORR_MAX)) ? CORR_MAX : corr_shr[8:0];
        end
        if (i_cmd.out_load) begin
            r_out.throttle_out <= r_limit ? thr_lim : r_thr;
            r_out.slip_now     <= r_slip;
            r_out.limiting     <= r_limit;
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

[rtl/stpl_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module stpl_ctrl #(
    parameter int SLIP_FRAC_BITS = stpl_pkg::SLIP_FRAC_BITS_DEF,
    parameter int RPM_BITS       = stpl_pkg::RPM_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output stpl_pkg::t_dp_cmd o_cmd
);
    import stpl_pkg::*;

    localparam int DivW = RPM_BITS + SLIP_FRAC_BITS;
    localparam int CntW = $clog2(DivW);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DIV    = 13'b0000000000010,
        S_SAT    = 13'b0000000000100,
        S_MUL_A  = 13'b0000000001000,
        S_MUL_B  = 13'b0000000010000,
        S_FILT   = 13'b0000000100000,
        S_ERR    = 13'b0000001000000,
        S_MUL_I  = 13'b0000010000000,
        S_INTEG  = 13'b0000100000000,
        S_MUL_LO = 13'b0001000000000,
        S_MUL_HI = 13'b0010000000000,
        S_CORR   = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } t_state;

    t_state          r_state;
    t_state          n_state;
    logic [CntW-1:0] r_cnt;
    logic [CntW-1:0] n_cnt;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            in_acc;
    logic            slot_free;

    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DIV;
                    n_cnt   = CntW'(DivW - 1);
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_SAT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_SAT:    n_state = S_MUL_A;
            S_MUL_A:  n_state = S_MUL_B;
            S_MUL_B:  n_state = S_FILT;
            S_FILT:   n_state = S_ERR;
            S_ERR:    n_state = S_MUL_I;
            S_MUL_I:  n_state = S_INTEG;
            S_INTEG:  n_state = S_MUL_LO;
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_CORR;
            S_CORR:   n_state = S_OUT;
            S_OUT: begin
                // hold until the output register is free
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = in_acc;
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.sat      = (r_state == S_SAT);
        o_cmd.mul_a    = (r_state == S_MUL_A);
        o_cmd.mul_b    = (r_state == S_MUL_B);
        o_cmd.filt     = (r_state == S_FILT);
        o_cmd.err      = (r_state == S_ERR);
        o_cmd.mul_i    = (r_state == S_MUL_I);
        o_cmd.integ    = (r_state == S_INTEG);
        o_cmd.mul_lo   = (r_state == S_MUL_LO);
        o_cmd.mul_hi   = (r_state == S_MUL_HI);
        o_cmd.corr     = (r_state == S_CORR);
        o_cmd.out_load = (r_state == S_OUT) && slot_free;
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire
